@@ sv/mcg_pkg.sv @@
// Shared types and constants of the month calendar grid block.
`default_nettype none
package mcg_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int ROW_W   = 3;
	localparam int WDAY_W  = 3;

	localparam int GRID_ROWS = 6;
	localparam int GRID_COLS = 7;
	localparam int NUM_MONTHS = 12;

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);

	localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
	localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
	localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [DAY_W-1:0]   LEAP_FEB_DAYS = 5'd29;

	// floor(x / 100) = (x * RECIP_100) >> RECIP_100_SH for any 14-bit x
	localparam int RECIP_100_W  = 13;
	localparam int RECIP_100_SH = 19;
	localparam logic [RECIP_100_W-1:0] RECIP_100 = 13'd5243;

	// floor(x / 7) = (x * RECIP_7) >> RECIP_7_SH for any 14-bit x
	localparam int RECIP_7_W  = 16;
	localparam int RECIP_7_SH = 18;
	localparam logic [RECIP_7_W-1:0] RECIP_7 = 16'd37450;

	// weekday offset table of the months, January first
	localparam logic [2:0] MONTH_OFFSET [NUM_MONTHS] = '{
		3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3,
		3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4
	};

	localparam logic [DAY_W-1:0] MONTH_DAYS [NUM_MONTHS] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// One classified month waiting for the row sequencer
	typedef struct packed {
		logic              err;
		logic [WDAY_W-1:0] start;
		logic [DAY_W-1:0]  len;
	} mcg_desc_t;

endpackage
`default_nettype wire

@@ sv/month_calendar_grid.sv @@
// Top level of the month calendar grid block.
// Each accepted item (year, month) yields six row items, row 0 to 5, each holding seven
// day numbers with 0 for a blank cell; last marks row 5. A year outside 1..9999 or a
// month outside 1..12 yields a single item with error and last set and all else zero.
// The front end takes one item per cycle into a four-stage pipeline (range check,
// divide by 100 through reciprocal multiply, weekday sum and month length, mod 7) and
// parks the result in a QUEUE_DEPTH-entry queue; input stalls once QUEUE_DEPTH items
// sit in the pipeline and the queue together. The row sequencer drains one row per
// cycle while out_stall is low: six rows for a valid month, one for an error item; it
// sets the sustained rate. An item passes the pipeline stages, the queue and the
// output register before its first row is shown. The Monday week start bit is written
// through the cfg port, which is always ready; write it only while the block is idle.
`default_nettype none
module month_calendar_grid import mcg_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [YEAR_W-1:0]  year,
	input  wire logic [MONTH_W-1:0] month,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [ROW_W-1:0]        row,
	output logic [DAY_W-1:0]        cell0,
	output logic [DAY_W-1:0]        cell1,
	output logic [DAY_W-1:0]        cell2,
	output logic [DAY_W-1:0]        cell3,
	output logic [DAY_W-1:0]        cell4,
	output logic [DAY_W-1:0]        cell5,
	output logic [DAY_W-1:0]        cell6,
	output logic                    last,
	output logic                    error
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic              week_mon_q;
	logic              push, pop, head_valid;
	mcg_desc_t         wr_desc, head;
	logic [CW-1:0]     level;
	logic [DAY_W-1:0]  cells [GRID_COLS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			week_mon_q <= 1'b0;
		else if (cfg_valid)
			week_mon_q <= cfg_data;
	end

	mcg_front #(
		.DEPTH (QUEUE_DEPTH),
		.CW    (CW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.year         (year),
		.month        (month),
		.week_mon     (week_mon_q),
		.level        (level),
		.push         (push),
		.desc         (wr_desc)
	);

	mcg_queue #(
		.DEPTH (QUEUE_DEPTH),
		.CW    (CW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_desc    (wr_desc),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.level      (level)
	);

	mcg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row        (row),
		.cells      (cells),
		.last       (last),
		.error      (error)
	);

	assign cell0 = cells[0];
	assign cell1 = cells[1];
	assign cell2 = cells[2];
	assign cell3 = cells[3];
	assign cell4 = cells[4];
	assign cell5 = cells[5];
	assign cell6 = cells[6];

endmodule
`default_nettype wire

@@ sv/mcg_front.sv @@
// Front end: accepts year/month items, checks range, finds first weekday and month length.
`default_nettype none
module mcg_front import mcg_pkg::*; #(
	parameter int DEPTH = 4,
	parameter int CW    = 3
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [YEAR_W-1:0]  year,
	input  wire logic [MONTH_W-1:0] month,
	input  wire logic               week_mon,
	input  wire logic [CW-1:0]      level,
	output logic                    push,
	output mcg_desc_t               desc
);

	localparam int SW = CW + 3;
	localparam int P100_W = YEAR_W + RECIP_100_W;
	localparam int P7_W   = YEAR_W + RECIP_7_W;

	logic accept;
	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1: raw fields
	logic [YEAR_W-1:0] y_s1, yp_s1;
	logic [3:0]        midx_s1;
	logic              feb_s1, err_s1, mon_s1;

	// stage 2: quotients by 100
	logic [YEAR_W-1:0] y_s2, yp_s2;
	logic [7:0]        qy_s2, qyp_s2;
	logic [3:0]        midx_s2;
	logic              feb_s2, err_s2, mon_s2;

	// stage 3: weekday sum and month length
	logic [YEAR_W-1:0] sum_s3;
	logic [DAY_W-1:0]  len_s3;
	logic              err_s3, mon_s3;

	// stage 4: finished descriptor
	mcg_desc_t desc_s4;

	logic [SW-1:0]      occupied;
	logic               err_in, early;
	logic [3:0]         midx_in;
	logic [P100_W-1:0]  py, pyp;
	logic [14:0]        hundred, sum_w;
	logic               div4, div100, div400, leap;
	logic [P7_W-1:0]    p7;
	logic [11:0]        q7;
	logic [14:0]        q7x7;
	logic [WDAY_W-1:0]  rem7, start;

	// credit check: never let more items in than the queue can hold
	assign occupied = SW'(level) + SW'(v_s1) + SW'(v_s2) + SW'(v_s3) + SW'(v_s4);
	assign in_stall = (occupied >= SW'(DEPTH));
	assign accept   = in_valid && !in_stall;

	always_comb begin
		err_in  = (year < YEAR_MIN) || (year > YEAR_MAX) ||
		          (month == '0) || (month > MONTH_MAX);
		early   = (month < MONTH_MAR);
		midx_in = err_in ? 4'd0 : (month - 4'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			y_s1    <= year;
			yp_s1   <= early ? (year - 14'd1) : year;
			midx_s1 <= midx_in;
			feb_s1  <= (month == MONTH_FEB);
			err_s1  <= err_in;
			mon_s1  <= week_mon;
		end
	end

	assign py  = P100_W'(y_s1) * P100_W'(RECIP_100);
	assign pyp = P100_W'(yp_s1) * P100_W'(RECIP_100);

	always_ff @(posedge clk) begin
		y_s2    <= y_s1;
		yp_s2   <= yp_s1;
		qy_s2   <= py[RECIP_100_SH +: 8];
		qyp_s2  <= pyp[RECIP_100_SH +: 8];
		midx_s2 <= midx_s1;
		feb_s2  <= feb_s1;
		err_s2  <= err_s1;
		mon_s2  <= mon_s1;
	end

	always_comb begin
		hundred = 15'(qy_s2) * 15'd100;
		div4    = (y_s2[1:0] == 2'b00);
		div100  = (hundred == {1'b0, y_s2});
		div400  = div100 && (qy_s2[1:0] == 2'b00);
		leap    = div400 || (div4 && !div100);
		// y + y/4 - y/100 + y/400 + offset + 1, with y/400 = (y/100)/4
		sum_w   = {1'b0, yp_s2} + 15'(yp_s2[YEAR_W-1:2]) - 15'(qyp_s2)
		        + 15'(qyp_s2[7:2]) + 15'(MONTH_OFFSET[midx_s2]) + 15'd1;
	end

	always_ff @(posedge clk) begin
		sum_s3 <= sum_w[YEAR_W-1:0];
		len_s3 <= (feb_s2 && leap) ? LEAP_FEB_DAYS : MONTH_DAYS[midx_s2];
		err_s3 <= err_s2;
		mon_s3 <= mon_s2;
	end

	always_comb begin
		p7    = P7_W'(sum_s3) * P7_W'(RECIP_7);
		q7    = p7[RECIP_7_SH +: 12];
		q7x7  = {q7, 3'b000} - {3'b000, q7};
		rem7  = WDAY_W'({1'b0, sum_s3} - q7x7);
		// shift the column origin to Monday
		if (mon_s3)
			start = (rem7 == '0) ? 3'd6 : (rem7 - 3'd1);
		else
			start = rem7;
	end

	always_ff @(posedge clk) begin
		desc_s4.err   <= err_s3;
		desc_s4.start <= start;
		desc_s4.len   <= len_s3;
	end

	assign push = v_s4;
	assign desc = desc_s4;

endmodule
`default_nettype wire

@@ sv/mcg_queue.sv @@
// Short descriptor queue between the front end and the row sequencer.
`default_nettype none
module mcg_queue import mcg_pkg::*; #(
	parameter int DEPTH = 4,
	parameter int CW    = 3
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  mcg_desc_t      wr_desc,
	input  wire logic      pop,
	output mcg_desc_t      head,
	output logic           head_valid,
	output logic [CW-1:0]  level
);

	localparam int PW = $clog2(DEPTH);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

	mcg_desc_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : (wr_ptr_q + 1'b1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : (rd_ptr_q + 1'b1);
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

	// front end holds back input, so a push never meets a full queue
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_desc;
	end

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign level      = count_q;

endmodule
`default_nettype wire

@@ sv/mcg_back.sv @@
// Back end: walks one month descriptor through six grid rows, or one error row, into the output register.
`default_nettype none
module mcg_back import mcg_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  mcg_desc_t          head,
	input  wire logic          head_valid,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [ROW_W-1:0]   row,
	output logic [DAY_W-1:0]   cells [GRID_COLS],
	output logic               last,
	output logic               error
);

	logic               active_q;
	logic [ROW_W-1:0]   row_q;
	logic [5:0]         day_q;
	logic [DAY_W-1:0]   len_q;

	logic               out_valid_q, out_last_q, out_err_q;
	logic [ROW_W-1:0]   out_row_q;
	logic [DAY_W-1:0]   out_cell_q [GRID_COLS];

	logic               load, emit, first;
	logic [ROW_W-1:0]   nxt_row;
	logic [DAY_W-1:0]   nxt_cell [GRID_COLS];
	logic               nxt_last, nxt_err;
	logic [5:0]         nxt_day;
	logic [5:0]         val;

	assign load  = !out_valid_q || !out_stall;
	assign first = !active_q;
	assign emit  = load && (active_q || head_valid);
	assign pop   = load && first && head_valid;

	always_comb begin
		nxt_row  = row_q;
		nxt_last = (row_q == LAST_ROW);
		nxt_err  = 1'b0;
		nxt_day  = day_q + 6'd7;
		val      = '0;
		for (int c = 0; c < GRID_COLS; c++)
			nxt_cell[c] = '0;
		if (first) begin
			nxt_row  = '0;
			nxt_err  = head.err;
			nxt_last = head.err;
			nxt_day  = 6'd8 - 6'(head.start);
			if (!head.err) begin
				// row 0: blanks before the first weekday, then 1, 2, ...
				for (int c = 0; c < GRID_COLS; c++) begin
					if (WDAY_W'(c) >= head.start)
						nxt_cell[c] = 5'(c) - 5'(head.start) + 5'd1;
				end
			end
		end else begin
			for (int c = 0; c < GRID_COLS; c++) begin
				val = day_q + 6'(c);
				if (val <= 6'(len_q))
					nxt_cell[c] = val[DAY_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				if (first) begin
					active_q <= !head.err;
					row_q    <= ROW_W'(1);
				end else begin
					row_q <= row_q + 1'b1;
					if (row_q == LAST_ROW)
						active_q <= 1'b0;
				end
			end else if (load) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			day_q      <= nxt_day;
			if (first)
				len_q <= head.len;
			out_row_q  <= nxt_row;
			out_cell_q <= nxt_cell;
			out_last_q <= nxt_last;
			out_err_q  <= nxt_err;
		end
	end

	assign out_valid = out_valid_q;
	assign row       = out_row_q;
	assign cells     = out_cell_q;
	assign last      = out_last_q;
	assign error     = out_err_q;

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the month calendar grid block.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import mcg_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_PAUSE = 16;
	localparam int HOLD_CYCLES = 400;

	// weekday offsets and plain month lengths, January first
	localparam int WDAY_OFS [NUM_MONTHS] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
	localparam int DAYS_IN  [NUM_MONTHS] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
	} month_req_t;

	typedef struct packed {
		logic [ROW_W-1:0]                  row;
		logic [GRID_COLS-1:0][DAY_W-1:0]   cells;
		logic                              last;
		logic                              error;
	} week_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [YEAR_W-1:0] year = '0;
	logic [MONTH_W-1:0] month = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ROW_W-1:0] row;
	logic [DAY_W-1:0] cell0, cell1, cell2, cell3, cell4, cell5, cell6;
	logic last;
	logic error;

	month_req_t month_q [$];
	week_row_t  week_rows_q [$];
	month_req_t next_month;
	week_row_t  got_row, want_row;

	logic week_mon_now = 1'b0;
	logic in_took = 1'b0;
	logic calm = 1'b0;
	logic hold_go = 1'b0;
	logic hold_used = 1'b0;
	int   hold_left = 0;
	int   send_gap = 0;
	int   stall_gap = 0;
	int   queued_months = 0;
	int   accepted_months = 0;
	int   mismatches = 0;
	int   cycles = 0;

	month_calendar_grid dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.year      (year),
		.month     (month),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.row       (row),
		.cell0     (cell0),
		.cell1     (cell1),
		.cell2     (cell2),
		.cell3     (cell3),
		.cell4     (cell4),
		.cell5     (cell5),
		.cell6     (cell6),
		.last      (last),
		.error     (error)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at %0t %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic bit is_leap(input int y);
		return (y % 400 == 0) || (y % 100 != 0 && y % 4 == 0);
	endfunction

	// Queue the rows that one month item must produce
	function automatic void predict_month(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m);
		week_row_t r;
		int yy, first, len, day, ri, ci;
		bit filled;
		r = '0;
		if (y < YEAR_MIN || y > YEAR_MAX || m == 0 || m > MONTH_MAX) begin
			r.last = 1'b1;
			r.error = 1'b1;
			week_rows_q.push_back(r);
			return;
		end
		yy = int'(y);
		if (m < 3)
			yy--;
		first = (yy + yy / 4 - yy / 100 + yy / 400 + WDAY_OFS[m - 1] + 1) % 7;
		if (week_mon_now)
			first = (first + 6) % 7;
		len = (m == 2 && is_leap(int'(y))) ? 29 : DAYS_IN[m - 1];
		day = 1;
		for (ri = 0; ri < GRID_ROWS; ri++) begin
			r = '0;
			r.row = ROW_W'(ri);
			for (ci = 0; ci < GRID_COLS; ci++) begin
				filled = !(ri == 0 && ci < first) && day <= len;
				r.cells[ci] = filled ? DAY_W'(day) : '0;
				if (filled)
					day++;
			end
			r.last = (ri == GRID_ROWS - 1);
			week_rows_q.push_back(r);
		end
	endfunction

	// Input side: record acceptance and predict
	always @(posedge clk) begin
		in_took <= in_valid && !in_stall;
		if (in_valid && !in_stall) begin
			predict_month(year, month);
			accepted_months++;
		end
	end

	// Sender: hold the item until taken, then advance or idle
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (send_gap != 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(0, 6);
				in_valid <= 1'b0;
			end else if (month_q.size() != 0) begin
				next_month = month_q.pop_front();
				in_valid <= 1'b1;
				year <= next_month.year;
				month <= next_month.month;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall: random bursts plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_go && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (stall_gap != 0) begin
				stall_gap--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_gap = $urandom_range(0, 6);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Output side: compare each row item with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_row.row = row;
			got_row.cells = {cell6, cell5, cell4, cell3, cell2, cell1, cell0};
			got_row.last = last;
			got_row.error = error;
			if (week_rows_q.size() == 0) begin
				flag_mismatch("row item with none pending, row", int'(row), -1);
			end else begin
				want_row = week_rows_q.pop_front();
				if (got_row.row != want_row.row)
					flag_mismatch("row", int'(got_row.row), int'(want_row.row));
				for (int c = 0; c < GRID_COLS; c++)
					if (got_row.cells[c] != want_row.cells[c])
						flag_mismatch($sformatf("cell%0d of row %0d", c, want_row.row),
							int'(got_row.cells[c]), int'(want_row.cells[c]));
				if (got_row.last != want_row.last)
					flag_mismatch("last", int'(got_row.last), int'(want_row.last));
				if (got_row.error != want_row.error)
					flag_mismatch("error", int'(got_row.error), int'(want_row.error));
			end
		end
	end

	task automatic add_month(input int y, input int m);
		month_req_t req;
		req.year = YEAR_W'(y);
		req.month = MONTH_W'(m);
		month_q.push_back(req);
		queued_months++;
	endtask

	task automatic add_directed();
		add_month(0, 1);
		add_month(10000, 6);
		add_month(16383, 15);
		add_month(2024, 0);
		add_month(2024, 13);
		add_month(0, 0);
		add_month(1, 1);
		add_month(1, 2);
		add_month(1, 12);
		add_month(9999, 1);
		add_month(9999, 12);
		add_month(2000, 2);
		add_month(1900, 2);
		add_month(2100, 2);
		add_month(2400, 2);
		add_month(2024, 2);
		add_month(2023, 2);
		add_month(2015, 2);
		add_month(2021, 2);
		add_month(2026, 8);
		add_month(2021, 5);
		add_month(8192, 3);
		add_month(4095, 7);
		add_month(1752, 9);
	endtask

	task automatic add_random(input int n);
		int k, sel, y, m;
		for (k = 0; k < n; k++) begin
			sel = $urandom_range(0, 19);
			y = $urandom_range(1, 9999);
			m = $urandom_range(1, 12);
			if (sel == 0)
				y = $urandom_range(10000, 16383);
			else if (sel == 1)
				m = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 15);
			else if (sel == 2)
				y = 0;
			else if (sel < 6) begin
				// stress the century leap rule
				y = 100 * $urandom_range(1, 99);
				m = $urandom_range(1, 3);
			end else if (sel < 8)
				m = 2;
			add_month(y, m);
		end
	endtask

	task automatic wait_drained();
		while (accepted_months != queued_months || week_rows_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);
	endtask

	task automatic write_week_start(input logic v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		week_mon_now = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		write_week_start(1'b0);
		add_directed();
		wait_drained();

		write_week_start(1'b1);
		add_directed();
		wait_drained();

		write_week_start(1'b0);
		add_random(100);
		// stall the output long enough to back up into the input
		hold_go = 1'b1;
		wait_drained();

		write_week_start(1'b1);
		add_random(100);
		wait_drained();

		write_week_start(1'b0);
		calm = 1'b1;
		add_random(102);
		wait_drained();

		if (mismatches == 0 && week_rows_q.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
`default_nettype wire
